/* sv/mtg_pkg.sv */
// Constants and word functions of the MT19937 generator core.
// Depends on nothing; imported by mersenne_twister_generator_core.
package mtg_pkg;

  localparam int unsigned TABLE_WORDS = 624;
  localparam int unsigned TWIST_SHIFT = 397;
  localparam int unsigned IDX_W       = $clog2(TABLE_WORDS);

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_WORDS - 1);
  localparam logic [IDX_W-1:0] FAR_FWD   = IDX_W'(TWIST_SHIFT);
  localparam logic [IDX_W-1:0] FAR_BACK  = IDX_W'(TABLE_WORDS - TWIST_SHIFT);

  localparam logic [31:0] INIT_MULT  = 32'h6c07_8965;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

  localparam logic REQ_RESEED = 1'b0;
  localparam logic REQ_DRAW   = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEED = 4'b0010,
    ST_RD1  = 4'b0100,
    ST_RD2  = 4'b1000
  } mtg_state_t;

  // New value of one table word from itself, its successor and its far partner.
  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] mix;
    logic [31:0] v;
    mix = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    v   = far ^ (mix >> 1);
    if (mix[0]) begin
      v = v ^ TWIST_XOR;
    end
    return v;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w_in);
    logic [31:0] w;
    w = w_in;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    return w;
  endfunction

endpackage

/* sv/mersenne_twister_generator_core.sv */
// MT19937 pseudo-random generator core: state table memory, reseed walk and draws.
// Depends on mtg_pkg for constants, the state type and the twist and temper functions.
//
//  Channel  | Ports                                   | Beat taken when
//  ---------+-----------------------------------------+----------------------------
//  input    | start, busy, in_req_type, in_seed       | start high and busy low
//  result   | out_valid, out_random_word              | out_valid high (one cycle)
//
// A draw keeps busy high through ST_RD1 and ST_RD2 after its accepting edge; its
// word is on the result ports in the cycle after ST_RD2, when the next beat may
// already be taken. The pace of draws is set by the three table reads a word
// needs through the two read ports of the state memory.
// A reseed keeps busy high while the seed walk writes one table word a cycle
// through the single write port. Reset clears control state only; the table
// holds garbage until the first reseed. The receiver cannot stall results.
module mersenne_twister_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_seed,
  output logic        out_valid,
  output logic [31:0] out_random_word
);
  import mtg_pkg::*;

  // State table: one write port, two registered read ports.
  logic [31:0] table_mem [TABLE_WORDS];
  logic [31:0] rdata0_r;
  logic [31:0] rdata1_r;
  logic [IDX_W-1:0] raddr0;
  logic [IDX_W-1:0] raddr1;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             wen;

  mtg_state_t state_r, state_nxt;
  logic [IDX_W-1:0] read_index_r, read_index_nxt;
  logic [IDX_W-1:0] seed_k_r, seed_k_nxt;
  logic [31:0]      seed_prev_r, seed_prev_nxt;
  logic [31:0]      cur_r, nxt_word_r;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_word_r;

  logic             accept;
  logic [IDX_W-1:0] succ_index;
  logic [IDX_W-1:0] far_index;
  logic [31:0]      seed_mix;
  logic [31:0]      seed_prod;
  logic [31:0]      seed_word;
  logic [31:0]      twisted;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Neighbors of the word being drawn. The successor of the last word wraps to
  // word 0, and the far partner wraps once the index reaches TABLE_WORDS - TWIST_SHIFT.
  assign succ_index = (read_index_r == LAST_IDX) ? '0 : read_index_r + IDX_W'(1);
  assign far_index  = (read_index_r < FAR_BACK) ? read_index_r + FAR_FWD
                                                : read_index_r - FAR_BACK;

  // The table is twisted lazily, one word per draw. At draw k every word below k
  // already holds its new value and every word from k up still holds its old one,
  // which is exactly what the in-place sequential twist would see for word k.
  assign twisted = twist_word(cur_r, nxt_word_r, rdata0_r);

  // Seed recurrence: w[k] = INIT_MULT * (w[k-1] ^ (w[k-1] >> 30)) + k, mod 2^32.
  assign seed_mix  = seed_prev_r ^ (seed_prev_r >> 30);
  assign seed_prod = INIT_MULT * seed_mix;
  assign seed_word = seed_prod + {{(32 - IDX_W){1'b0}}, seed_k_r};

  always_comb begin
    state_nxt      = state_r;
    read_index_nxt = read_index_r;
    seed_k_nxt     = seed_k_r;
    seed_prev_nxt  = seed_prev_r;
    out_valid_nxt  = 1'b0;
    raddr0         = read_index_r;
    raddr1         = succ_index;
    waddr          = read_index_r;
    wdata          = twisted;
    wen            = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // Port reads of the current and successor words are issued every idle
        // cycle, so an accepted draw finds both in the read registers.
        if (accept) begin
          if (in_req_type == REQ_RESEED) begin
            wen            = 1'b1;
            waddr          = '0;
            wdata          = in_seed;
            seed_prev_nxt  = in_seed;
            seed_k_nxt     = IDX_W'(1);
            read_index_nxt = '0;
            state_nxt      = ST_SEED;
          end else begin
            state_nxt = ST_RD1;
          end
        end
      end
      ST_SEED: begin
        wen           = 1'b1;
        waddr         = seed_k_r;
        wdata         = seed_word;
        seed_prev_nxt = seed_word;
        seed_k_nxt    = seed_k_r + IDX_W'(1);
        if (seed_k_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD1: begin
        raddr0    = far_index;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        wen            = 1'b1;
        waddr          = read_index_r;
        wdata          = twisted;
        out_valid_nxt  = 1'b1;
        read_index_nxt = succ_index;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      table_mem[waddr] <= wdata;
    end
    rdata0_r <= table_mem[raddr0];
    rdata1_r <= table_mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_index_r <= '0;
      seed_k_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_index_r <= read_index_nxt;
      seed_k_r     <= seed_k_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    seed_prev_r <= seed_prev_nxt;
    if (state_r == ST_RD1) begin
      cur_r      <= rdata0_r;
      nxt_word_r <= rdata1_r;
    end
    if (state_r == ST_RD2) begin
      out_word_r <= temper(twisted);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // A result beat only ever follows the write-back cycle of a draw.
  a_out_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_RD2))
    else $error("result strobe without a completed draw");

  // The read index never leaves the table.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    read_index_r <= LAST_IDX)
    else $error("read index beyond table");

  // An accepted reseed starts the walk at word 1 with the index cleared.
  a_reseed_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_RESEED) |=>
      (state_r == ST_SEED && seed_k_r == IDX_W'(1) && read_index_r == '0))
    else $error("reseed did not start the seed walk");

  // The seed walk stays within words 1 to the last.
  a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED) |-> (seed_k_r != '0 && seed_k_r <= LAST_IDX))
    else $error("seed walk index out of range");

endmodule
